// ===== rtl/sida_pkg.sv =====
// shared constants and types for the signed integer to decimal text converter
`default_nettype none

package sida_pkg;

    localparam int VALUE_WIDTH = 32;
    localparam int MAG_W       = VALUE_WIDTH + 1;
    localparam int DIGIT_DEPTH = (VALUE_WIDTH * 30103) / 100000 + 1;
    localparam int DIG_IDX_W   = $clog2(DIGIT_DEPTH);
    localparam int CNT_W       = $clog2(DIGIT_DEPTH + 1);
    localparam int BIT_CNT_W   = $clog2(MAG_W + 1);

    localparam logic [6:0] CHAR_ZERO  = 7'd48;
    localparam logic [6:0] CHAR_NINE  = 7'd57;
    localparam logic [6:0] CHAR_MINUS = 7'd45;

    typedef logic [DIGIT_DEPTH-1:0][3:0] bcd_t;

endpackage

`default_nettype wire

// ===== rtl/signed_int_to_decimal_ascii.sv =====
// top level: signed integer in, decimal ascii characters out
// Each accepted value is converted to its magnitude (one bit wider than the value,
// so the most negative value prints exactly) and run through a shift-and-add-3
// bcd unit, one magnitude bit per cycle. A count state then finds the highest
// nonzero digit, then the characters leave one per cycle while the output is
// free, a '-' first for negative values, most significant digit first,
// last_char high on the final digit. s_ready is high only while no conversion
// or emission runs; the final character may still wait in the output register
// while the next value is taken.
`default_nettype none

module signed_int_to_decimal_ascii (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    input  wire logic                                 s_valid,
    output logic                                      s_ready,
    input  wire logic signed [sida_pkg::VALUE_WIDTH-1:0] s_value,
    output logic                                      m_valid,
    input  wire logic                                 m_ready,
    output logic [6:0]                                m_char_code,
    output logic                                      m_last_char
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_CONV  = 3'd1;
    localparam logic [2:0] ST_COUNT = 3'd2;
    localparam logic [2:0] ST_SIGN  = 3'd3;
    localparam logic [2:0] ST_EMIT  = 3'd4;

    logic [2:0]                         state_reg, state_next;
    logic [sida_pkg::MAG_W-1:0]         mag_reg, mag_next;
    logic                               neg_reg, neg_next;
    logic [sida_pkg::BIT_CNT_W-1:0]     bit_cnt_reg, bit_cnt_next;
    sida_pkg::bcd_t                     bcd_reg, bcd_next;
    logic [sida_pkg::DIG_IDX_W-1:0]     idx_reg, idx_next;
    logic                               m_valid_reg, m_valid_next;
    logic [6:0]                         m_char_reg, m_char_next;
    logic                               m_last_reg, m_last_next;

    sida_pkg::bcd_t                     bcd_step;
    logic [sida_pkg::CNT_W-1:0]         digit_count;
    logic [sida_pkg::MAG_W-1:0]         mag_init;
    logic                               out_free;

    sida_dabble u_dabble (
        .bcd_in  (bcd_reg),
        .bit_in  (mag_reg[sida_pkg::MAG_W-1]),
        .bcd_out (bcd_step)
    );

    assign s_ready     = (state_reg == ST_IDLE);
    assign m_valid     = m_valid_reg;
    assign m_char_code = m_char_reg;
    assign m_last_char = m_last_reg;
    assign out_free    = !m_valid_reg || m_ready;

    assign mag_init = s_value[sida_pkg::VALUE_WIDTH-1]
                    ? sida_pkg::MAG_W'(0) - {s_value[sida_pkg::VALUE_WIDTH-1], s_value}
                    : {1'b0, s_value};

    // highest nonzero digit, at least one digit
    always_comb begin
        digit_count = sida_pkg::CNT_W'(1);
        for (int i = 0; i < sida_pkg::DIGIT_DEPTH; i++) begin
            if (bcd_reg[i] != 4'd0) begin
                digit_count = sida_pkg::CNT_W'(i + 1);
            end
        end
    end

    always_comb begin
        state_next   = state_reg;
        mag_next     = mag_reg;
        neg_next     = neg_reg;
        bit_cnt_next = bit_cnt_reg;
        bcd_next     = bcd_reg;
        idx_next     = idx_reg;
        m_valid_next = m_valid_reg;
        m_char_next  = m_char_reg;
        m_last_next  = m_last_reg;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    neg_next     = s_value[sida_pkg::VALUE_WIDTH-1];
                    mag_next     = mag_init;
                    bcd_next     = '0;
                    bit_cnt_next = sida_pkg::BIT_CNT_W'(sida_pkg::MAG_W);
                    state_next   = ST_CONV;
                end
            end
            ST_CONV: begin
                bcd_next     = bcd_step;
                mag_next     = {mag_reg[sida_pkg::MAG_W-2:0], 1'b0};
                bit_cnt_next = bit_cnt_reg - 1'b1;
                if (bit_cnt_reg == sida_pkg::BIT_CNT_W'(1)) begin
                    state_next = ST_COUNT;
                end
            end
            ST_COUNT: begin
                idx_next   = sida_pkg::DIG_IDX_W'(digit_count - 1'b1);
                state_next = neg_reg ? ST_SIGN : ST_EMIT;
            end
            ST_SIGN: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_char_next  = sida_pkg::CHAR_MINUS;
                    m_last_next  = 1'b0;
                    state_next   = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_char_next  = sida_pkg::CHAR_ZERO + {3'b000, bcd_reg[idx_reg]};
                    m_last_next  = (idx_reg == '0);
                    if (idx_reg == '0) begin
                        state_next = ST_IDLE;
                    end else begin
                        idx_next = idx_reg - 1'b1;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            mag_reg     <= '0;
            neg_reg     <= 1'b0;
            bit_cnt_reg <= '0;
            idx_reg     <= '0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            mag_reg     <= mag_next;
            neg_reg     <= neg_next;
            bit_cnt_reg <= bit_cnt_next;
            idx_reg     <= idx_next;
        end
    end

    always_ff @(posedge aclk) begin
        bcd_reg    <= bcd_next;
        m_char_reg <= m_char_next;
        m_last_reg <= m_last_next;
    end

`ifndef SYNTHESIS
    a_accept_starts_conv: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> state_reg == ST_CONV)
        else $error("transfer accepted without starting conversion");

    a_conv_ends_in_count: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_CONV && bit_cnt_reg == sida_pkg::BIT_CNT_W'(1)
        |=> state_reg == ST_COUNT)
        else $error("conversion did not end after the last magnitude bit");

    a_char_legal: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> m_char_reg == sida_pkg::CHAR_MINUS
                     || (m_char_reg >= sida_pkg::CHAR_ZERO
                         && m_char_reg <= sida_pkg::CHAR_NINE))
        else $error("output character is neither a digit nor a minus sign");

    a_minus_not_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_char_reg == sida_pkg::CHAR_MINUS |-> !m_last_reg)
        else $error("minus sign flagged as last character");
`endif

endmodule

`default_nettype wire

// ===== rtl/sida_dabble.sv =====
// one shift-and-add-3 step of the binary to bcd conversion
`default_nettype none

module sida_dabble (
    input  sida_pkg::bcd_t bcd_in,
    input  logic           bit_in,
    output sida_pkg::bcd_t bcd_out
);

    logic [4*sida_pkg::DIGIT_DEPTH-1:0] adj_flat;

    always_comb begin
        for (int i = 0; i < sida_pkg::DIGIT_DEPTH; i++) begin
            if (bcd_in[i] >= 4'd5) begin
                adj_flat[4*i +: 4] = bcd_in[i] + 4'd3;
            end else begin
                adj_flat[4*i +: 4] = bcd_in[i];
            end
        end
    end

    assign bcd_out = sida_pkg::bcd_t'({adj_flat[4*sida_pkg::DIGIT_DEPTH-2:0], bit_in});

endmodule

`default_nettype wire

// ===== tb/decimal_text_check.sv =====
// monitor and scoreboard for the signed integer to decimal ascii converter
`timescale 1ns / 1ps

module decimal_text_check (
    input  wire logic                                    aclk,
    input  wire logic                                    aresetn,
    input  wire logic                                    s_valid,
    input  wire logic                                    s_ready,
    input  wire logic signed [sida_pkg::VALUE_WIDTH-1:0] s_value,
    input  wire logic                                    m_valid,
    input  wire logic                                    m_ready,
    input  wire logic [6:0]                              m_char_code,
    input  wire logic                                    m_last_char,
    output int                                           error_count,
    output int                                           pending_chars
);

    typedef struct packed {
        logic [6:0] code;
        logic       last;
    } text_char_t;

    text_char_t text_q[$];
    int         err_tally = 0;

    // decimal text of one value, sign first, most significant digit first
    function automatic void predict_text(input logic signed [sida_pkg::VALUE_WIDTH-1:0] v);
        logic [sida_pkg::MAG_W-1:0] ext;
        logic [sida_pkg::MAG_W-1:0] mag;
        logic [3:0]                 digits[sida_pkg::DIGIT_DEPTH];
        int                         n;
        logic                       neg;
        text_char_t                 c;

        neg = v[sida_pkg::VALUE_WIDTH-1];
        ext = {v[sida_pkg::VALUE_WIDTH-1], v};
        mag = neg ? (~ext + 1'b1) : ext;
        n   = 0;
        do begin
            digits[n] = 4'(mag % 10);
            mag       = mag / 10;
            n++;
        end while (mag != 0);

        if (neg) begin
            c.code = sida_pkg::CHAR_MINUS;
            c.last = 1'b0;
            text_q.push_back(c);
        end
        for (int k = n - 1; k >= 0; k--) begin
            c.code = sida_pkg::CHAR_ZERO + 7'(digits[k]);
            c.last = (k == 0);
            text_q.push_back(c);
        end
    endfunction

    always @(posedge aclk) begin
        text_char_t want;

        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (text_q.size() == 0) begin
                    $error("unexpected character transfer: char_code %0d last_char %0b",
                           m_char_code, m_last_char);
                    err_tally++;
                end else begin
                    want = text_q.pop_front();
                    if (m_char_code !== want.code) begin
                        $error("char_code: expected %0d, actual %0d", want.code, m_char_code);
                        err_tally++;
                    end
                    if (m_last_char !== want.last) begin
                        $error("last_char: expected %0b, actual %0b", want.last, m_last_char);
                        err_tally++;
                    end
                end
            end
            if (s_valid && s_ready) begin
                predict_text(s_value);
            end
        end
        error_count   <= err_tally;
        pending_chars <= text_q.size();
    end

endmodule

// ===== tb/tb_signed_int_to_decimal_ascii.sv =====
// testbench top: stimulus, clock, reset and verdict for the decimal ascii converter
`timescale 1ns / 1ps

module tb_signed_int_to_decimal_ascii;

    localparam int CYCLE_LIMIT    = 400000;
    localparam int RANDOM_ITEMS   = 120;
    localparam int HOLD_OFF_TICKS = 400;
    localparam int CORNER_COUNT   = 21;

    logic                                    aclk    = 1'b0;
    logic                                    aresetn = 1'b0;
    logic                                    s_valid = 1'b0;
    logic                                    s_ready;
    logic signed [sida_pkg::VALUE_WIDTH-1:0] s_value = '0;
    logic                                    m_valid;
    logic                                    m_ready = 1'b0;
    logic [6:0]                              m_char_code;
    logic                                    m_last_char;

    int error_count;
    int pending_chars;
    int tx_idle_pct   = 0;
    int rx_idle_pct   = 0;
    int hold_requests = 0;
    int holds_served  = 0;
    int hold_left     = 0;
    int cycle_count   = 0;

    signed_int_to_decimal_ascii u_dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_value    (s_value),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_char_code(m_char_code),
        .m_last_char(m_last_char)
    );

    decimal_text_check u_check (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_value      (s_value),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_char_code  (m_char_code),
        .m_last_char  (m_last_char),
        .error_count  (error_count),
        .pending_chars(pending_chars)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("signed_int_to_decimal_ascii verification failed");
            $finish;
        end
    end

    // receiver: random stalls plus an occasional long hold-off
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (holds_served != hold_requests) begin
            holds_served++;
            hold_left = HOLD_OFF_TICKS;
            m_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    task automatic send_value(input logic [sida_pkg::VALUE_WIDTH-1:0] v);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_value <= v;
        do @(posedge aclk); while (!s_ready);
    endtask

    function automatic logic [sida_pkg::VALUE_WIDTH-1:0] pick_value();
        logic [sida_pkg::VALUE_WIDTH-1:0] v;
        int                               p;

        case ($urandom_range(4))
            0: v = $urandom;
            1: v = $urandom_range(99);
            2: begin
                p = 1;
                repeat ($urandom_range(9)) p = p * 10;
                v = p - 1 + $urandom_range(2);
            end
            3: v = $urandom_range(1) ? 32'h8000_0000 + $urandom_range(3)
                                      : 32'h7fff_ffff - $urandom_range(3);
            default: v = $urandom >> $urandom_range(31);
        endcase
        if ($urandom_range(1)) begin
            v = -v;
        end
        return v;
    endfunction

    task automatic random_phase(input int tx_pct, input int rx_pct, input bit with_hold);
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            if (with_hold && i == RANDOM_ITEMS / 3) begin
                hold_requests++;
            end
            send_value(pick_value());
        end
    endtask

    logic [sida_pkg::VALUE_WIDTH-1:0] corner_values[CORNER_COUNT] = '{
        32'd0, 32'd1, -32'sd1, 32'd9, 32'd10, -32'sd10, 32'd99, 32'd100,
        32'h7fff_ffff, 32'h8000_0000, 32'h8000_0001, 32'd1000000000,
        32'd999999999, -32'sd999999999, -32'sd1000000000, 32'd123456789,
        -32'sd7, 32'haaaa_aaaa, 32'h5555_5555, 32'd4294967, -32'sd100
    };

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        tx_idle_pct = 36;
        rx_idle_pct = 45;
        foreach (corner_values[i]) begin
            send_value(corner_values[i]);
        end

        random_phase(36, 45, 1'b1);
        random_phase(45, 36, 1'b0);
        random_phase(0, 0, 1'b1);

        s_valid <= 1'b0;
        do @(posedge aclk); while (pending_chars != 0);
        repeat (60) @(posedge aclk);

        if (error_count == 0) begin
            $display("signed_int_to_decimal_ascii verification clean");
        end else begin
            $display("signed_int_to_decimal_ascii verification failed");
        end
        $finish;
    end

endmodule

// ===== signed_int_to_decimal_ascii.f =====
rtl/sida_pkg.sv
rtl/sida_dabble.sv
rtl/signed_int_to_decimal_ascii.sv
tb/decimal_text_check.sv
tb/tb_signed_int_to_decimal_ascii.sv
